FILE: rtl/pxc_pkg.sv
package pxc_pkg;

    // payload of one input transaction
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } pxc_in_t;

    // payload of one result transaction
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } pxc_out_t;

    // line kinds picked by the first byte of a line
    typedef enum logic [3:0] {
        K_IGNORE  = 4'd0,
        K_OPEN    = 4'd1,
        K_ATTR    = 4'd2,
        K_TEXT    = 4'd3,
        K_PI      = 4'd4,
        K_DOCTYPE = 4'd5,
        K_COMMENT = 4'd6,
        K_CDATA   = 4'd7,
        K_CLOSE   = 4'd8
    } kind_t;

    // output fragments, each a fixed string or the input byte itself
    typedef enum logic [4:0] {
        S_NONE,
        S_LIT,
        S_GT,
        S_LT,
        S_SP,
        S_NL,
        S_TAB,
        S_BSL,
        S_QUOTE,
        S_PI_OPEN,
        S_DT_OPEN,
        S_COM_OPEN,
        S_CDATA_OPEN,
        S_CLOSE_OPEN,
        S_EQ_QUOTE,
        S_ENT_LT,
        S_ENT_GT,
        S_ENT_AMP,
        S_ENT_QUOT,
        S_PI_END,
        S_DT_END,
        S_COM_END,
        S_CDATA_END
    } str_t;

    localparam int unsigned TEXT_MAX        = 9;
    localparam int unsigned NSLOT           = 7;
    localparam int unsigned SLOT_W          = $clog2(NSLOT);
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    typedef logic [0:TEXT_MAX-1][7:0] text_t;

    // one item's worth of output, compacted to slots 0..last
    typedef struct packed {
        logic [7:0]                   lit;
        logic [SLOT_W-1:0]            last;
        str_t [NSLOT-1:0]             slot;
    } desc_t;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_C   = 8'h43;
    localparam logic [7:0] CH_UC_D   = 8'h44;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSL    = 8'h5C;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_T   = 8'h74;

    function automatic logic [3:0] str_len(str_t s);
        case (s)
            S_PI_OPEN:    return 4'd2;
            S_DT_OPEN:    return 4'd9;
            S_COM_OPEN:   return 4'd4;
            S_CDATA_OPEN: return 4'd9;
            S_CLOSE_OPEN: return 4'd2;
            S_EQ_QUOTE:   return 4'd2;
            S_ENT_LT:     return 4'd4;
            S_ENT_GT:     return 4'd4;
            S_ENT_AMP:    return 4'd5;
            S_ENT_QUOT:   return 4'd6;
            S_PI_END:     return 4'd3;
            S_DT_END:     return 4'd2;
            S_COM_END:    return 4'd4;
            S_CDATA_END:  return 4'd4;
            default:      return 4'd1;
        endcase
    endfunction

    // characters of a fragment, left aligned
    function automatic text_t str_text(str_t s, logic [7:0] lit);
        case (s)
            S_LIT:        return {lit, 64'h0};
            S_GT:         return {CH_GT, 64'h0};
            S_LT:         return {CH_LT, 64'h0};
            S_SP:         return {CH_SP, 64'h0};
            S_NL:         return {CH_NL, 64'h0};
            S_TAB:        return {CH_TAB, 64'h0};
            S_BSL:        return {CH_BSL, 64'h0};
            S_QUOTE:      return {CH_QUOTE, 64'h0};
            S_PI_OPEN:    return {"<?", 56'h0};
            S_DT_OPEN:    return "<!DOCTYPE";
            S_COM_OPEN:   return {"<!--", 40'h0};
            S_CDATA_OPEN: return "<![CDATA[";
            S_CLOSE_OPEN: return {"</", 56'h0};
            S_EQ_QUOTE:   return {"=", CH_QUOTE, 56'h0};
            S_ENT_LT:     return {"&lt;", 40'h0};
            S_ENT_GT:     return {"&gt;", 40'h0};
            S_ENT_AMP:    return {"&amp;", 32'h0};
            S_ENT_QUOT:   return {"&quot;", 24'h0};
            S_PI_END:     return {"?>", CH_NL, 48'h0};
            S_DT_END:     return {CH_GT, CH_NL, 56'h0};
            S_COM_END:    return {"-->", CH_NL, 40'h0};
            S_CDATA_END:  return {"]]>", CH_NL, 40'h0};
            default:      return {lit, 64'h0};
        endcase
    endfunction

endpackage

FILE: rtl/pxc_front.sv
module pxc_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  pxc_pkg::pxc_in_t item,
    input  logic             q_full,
    output logic             q_wr,
    output pxc_pkg::desc_t   q_data
);
    import pxc_pkg::*;

    kind_t kind_reg, kind_next;
    logic  at_start_reg, at_start_next;
    logic  tag_open_reg, tag_open_next;
    logic  vstart_reg, vstart_next;
    logic  bsp_reg, bsp_next;

    logic       take;
    logic [7:0] b;
    logic       eoi;
    str_t       cand [NSLOT];
    logic [3:0] n;
    logic [3:0] n_m1;

    function automatic str_t esc_code(kind_t k, logic [7:0] c);
        logic is_attr;
        logic is_text;
        is_attr = (k == K_ATTR);
        is_text = (k == K_TEXT) || (k == K_PI) || (k == K_DOCTYPE) || (k == K_COMMENT);
        if (c == CH_LT && (is_attr || is_text))
            return S_ENT_LT;
        else if (c == CH_GT && is_text)
            return S_ENT_GT;
        else if (c == CH_AMP && (is_attr || is_text))
            return S_ENT_AMP;
        else if (c == CH_QUOTE && is_attr)
            return S_ENT_QUOT;
        else
            return S_LIT;
    endfunction

    function automatic str_t fin_code(kind_t k, logic vs);
        case (k)
            K_ATTR:    return vs ? S_QUOTE : S_NONE;
            K_PI:      return S_PI_END;
            K_DOCTYPE: return S_DT_END;
            K_COMMENT: return S_COM_END;
            K_CDATA:   return S_CDATA_END;
            K_CLOSE:   return S_GT;
            default:   return S_NONE;
        endcase
    endfunction

    assign take = push && !q_full;
    assign b    = item.data_byte;
    assign eoi  = item.end_of_input;

    // classify the byte; cand holds the fragments in output order:
    // pending tag close, lone backslash, main fragment, backslash at
    // line end, line trailer, tag close at stream end, final newline
    always_comb
    begin
        kind_next     = kind_reg;
        at_start_next = at_start_reg;
        tag_open_next = tag_open_reg;
        vstart_next   = vstart_reg;
        bsp_next      = bsp_reg;
        for (int i = 0; i < NSLOT; i++)
            cand[i] = S_NONE;

        if (at_start_reg)
        begin
            if (tag_open_reg && b != CH_UC_A)
            begin
                cand[0]       = S_GT;
                tag_open_next = 1'b0;
            end
            if (b != CH_NL)
            begin
                at_start_next = 1'b0;
                vstart_next   = 1'b0;
                case (b)
                    CH_LPAREN:
                    begin
                        kind_next = K_OPEN;
                        cand[2]   = S_LT;
                    end
                    CH_UC_A:
                    begin
                        if (tag_open_reg)
                        begin
                            kind_next = K_ATTR;
                            cand[2]   = S_SP;
                        end
                        else
                            kind_next = K_IGNORE;
                    end
                    CH_DASH:   kind_next = K_TEXT;
                    CH_QMARK:
                    begin
                        kind_next = K_PI;
                        cand[2]   = S_PI_OPEN;
                    end
                    CH_UC_D:
                    begin
                        kind_next = K_DOCTYPE;
                        cand[2]   = S_DT_OPEN;
                    end
                    CH_UC_C:
                    begin
                        kind_next = K_COMMENT;
                        cand[2]   = S_COM_OPEN;
                    end
                    CH_LBRACK:
                    begin
                        kind_next = K_CDATA;
                        cand[2]   = S_CDATA_OPEN;
                    end
                    CH_RPAREN:
                    begin
                        kind_next = K_CLOSE;
                        cand[2]   = S_CLOSE_OPEN;
                    end
                    default:   kind_next = K_IGNORE;
                endcase
            end
            else if (tag_open_reg)
            begin
                cand[0]       = S_GT;
                tag_open_next = 1'b0;
            end
        end
        else if (b == CH_NL)
        begin
            if (bsp_reg)
            begin
                cand[3]  = S_BSL;
                bsp_next = 1'b0;
            end
            cand[4] = fin_code(kind_reg, vstart_reg);
            if (kind_reg == K_OPEN)
                tag_open_next = 1'b1;
            kind_next     = K_IGNORE;
            vstart_next   = 1'b0;
            at_start_next = 1'b1;
        end
        else
        begin
            case (kind_reg)
                K_OPEN, K_CLOSE: cand[2] = S_LIT;
                K_ATTR, K_TEXT, K_PI, K_DOCTYPE, K_COMMENT, K_CDATA:
                begin
                    if (kind_reg == K_ATTR && !vstart_reg)
                    begin
                        if (b == CH_SP)
                        begin
                            cand[2]     = S_EQ_QUOTE;
                            vstart_next = 1'b1;
                        end
                        else
                            cand[2] = S_LIT;
                    end
                    else if (bsp_reg)
                    begin
                        bsp_next = 1'b0;
                        if (b == CH_LC_N)
                            cand[2] = S_NL;
                        else if (b == CH_LC_T)
                            cand[2] = S_TAB;
                        else if (b == CH_BSL)
                            cand[2] = S_BSL;
                        else
                        begin
                            cand[1] = S_BSL;
                            cand[2] = esc_code(kind_reg, b);
                        end
                    end
                    else if (b == CH_BSL)
                        bsp_next = 1'b1;
                    else
                        cand[2] = esc_code(kind_reg, b);
                end
                default: ;
            endcase
        end

        // stream end: finish the line, close a pending tag, add newline
        if (eoi)
        begin
            if (!at_start_next)
            begin
                if (bsp_next)
                    cand[3] = S_BSL;
                cand[4] = fin_code(kind_next, vstart_next);
                if (kind_next == K_OPEN)
                    tag_open_next = 1'b1;
            end
            if (tag_open_next)
                cand[5] = S_GT;
            cand[6]       = S_NL;
            kind_next     = K_IGNORE;
            at_start_next = 1'b1;
            tag_open_next = 1'b0;
            vstart_next   = 1'b0;
            bsp_next      = 1'b0;
        end
    end

    // pack the used fragments to the front of the descriptor
    always_comb
    begin
        n = 4'd0;
        q_data.lit = b;
        for (int i = 0; i < NSLOT; i++)
            q_data.slot[i] = S_NONE;
        for (int i = 0; i < NSLOT; i++)
        begin
            if (cand[i] != S_NONE)
            begin
                q_data.slot[n[SLOT_W-1:0]] = cand[i];
                n = n + 4'd1;
            end
        end
        n_m1        = n - 4'd1;
        q_data.last = n_m1[SLOT_W-1:0];
    end

    assign q_wr = take && (n != 4'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg     <= K_IGNORE;
            at_start_reg <= 1'b1;
            tag_open_reg <= 1'b0;
            vstart_reg   <= 1'b0;
            bsp_reg      <= 1'b0;
        end
        else if (take)
        begin
            kind_reg     <= kind_next;
            at_start_reg <= at_start_next;
            tag_open_reg <= tag_open_next;
            vstart_reg   <= vstart_next;
            bsp_reg      <= bsp_next;
        end
    end

endmodule

FILE: rtl/pxc_queue.sv
module pxc_queue #(
    parameter int unsigned DEPTH = pxc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  pxc_pkg::desc_t wr_data,
    output logic           full,
    input  logic           rd_en,
    output pxc_pkg::desc_t rd_data,
    output logic           empty
);
    import pxc_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    desc_t            entry_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (rd_en && !wr_en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/pxc_back.sv
module pxc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  pxc_pkg::desc_t    q_data,
    output logic              q_rd,
    output logic              empty,
    input  logic              pop,
    output pxc_pkg::pxc_out_t result
);
    import pxc_pkg::*;

    logic [SLOT_W-1:0] sidx_reg, sidx_next;
    logic [3:0]        cidx_reg, cidx_next;
    logic              ovalid_reg, ovalid_next;
    pxc_out_t          obuf_reg, obuf_next;

    str_t       code;
    logic [3:0] len_m1;
    text_t      text;
    logic       last_char;
    logic       last_slot;
    logic       load;

    assign code      = q_data.slot[sidx_reg];
    assign len_m1    = str_len(code) - 4'd1;
    assign text      = str_text(code, q_data.lit);
    assign last_char = (cidx_reg == len_m1);
    assign last_slot = (sidx_reg == q_data.last);
    assign load      = !q_empty && (!ovalid_reg || pop);

    always_comb
    begin
        sidx_next   = sidx_reg;
        cidx_next   = cidx_reg;
        ovalid_next = ovalid_reg && !pop;
        obuf_next   = obuf_reg;
        q_rd        = 1'b0;
        if (load)
        begin
            ovalid_next           = 1'b1;
            obuf_next.out_byte    = text[cidx_reg];
            obuf_next.last_of_run = last_char && last_slot;
            if (last_char)
            begin
                cidx_next = 4'd0;
                if (last_slot)
                begin
                    sidx_next = '0;
                    q_rd      = 1'b1;
                end
                else
                    sidx_next = sidx_reg + 1'b1;
            end
            else
                cidx_next = cidx_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sidx_reg   <= '0;
            cidx_reg   <= 4'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            sidx_reg   <= sidx_next;
            cidx_reg   <= cidx_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        obuf_reg <= obuf_next;
    end

    assign empty  = !ovalid_reg;
    assign result = obuf_reg;

endmodule

FILE: rtl/pyx_to_xml_stream_converter.sv
// path: an accepted input transaction is written into the descriptor queue; its first result
// byte is then loaded from the queue into the output register that drives the result ports
// throughput: one input transaction per cycle while the queue has room; the back end
// sends one byte per cycle while its output is empty or being popped; an item expands to
// 1 byte for a plain body byte and up to 15 bytes at a line start or stream end
// reset: rst_n asynchronous active low, clears line state, queue and output valid flag
module pyx_to_xml_stream_converter #(
    parameter int unsigned QUEUE_DEPTH = pxc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  pxc_pkg::pxc_in_t  item,
    output logic              empty,
    input  logic              pop,
    output pxc_pkg::pxc_out_t result
);
    import pxc_pkg::*;

    // front to queue
    logic  q_wr;
    desc_t q_wdata;
    logic  q_full;

    // queue to back end
    logic  q_rd;
    desc_t q_rdata;
    logic  q_empty;

    // input side stalls only when the descriptor queue is full
    assign full = q_full;

    // front end: tracks line kind, pending tag and escapes, and turns each
    // input transaction into a compact list of output fragments
    pxc_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .item   (item),
        .q_full (q_full),
        .q_wr   (q_wr),
        .q_data (q_wdata)
    );

    // short queue so the front keeps taking bytes while the back end expands
    // entities and markers
    pxc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (q_wdata),
        .full    (q_full),
        .rd_en   (q_rd),
        .rd_data (q_rdata),
        .empty   (q_empty)
    );

    // back end: walks the fragments character by character into the
    // output register; a waiting result holds the front back only once the queue is full
    pxc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_rdata),
        .q_rd    (q_rd),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

FILE: test/xml_byte_checker.sv
`timescale 1ns / 100ps

module xml_byte_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic              full,
    input  pxc_pkg::pxc_in_t  item,
    input  logic              empty,
    input  logic              pop,
    input  pxc_pkg::pxc_out_t result,
    output int                fail_count,
    output int                due_count,
    output int                checked_count
);
    import pxc_pkg::*;

    localparam int MAX_RUN = 16;

    // line state of the converter as predicted here
    kind_t line_kind;
    bit    at_line_start;
    bit    tag_open;
    bit    value_started;
    bit    backslash_pending;

    logic [7:0] run_bytes[$];
    pxc_out_t   xml_bytes_due[$];
    int         mismatches;
    int         checked_n;
    int         pending_n;

    assign fail_count    = mismatches;
    assign due_count     = pending_n;
    assign checked_count = checked_n;

    function automatic void clear_line_state();
        line_kind         = K_IGNORE;
        at_line_start     = 1'b1;
        tag_open          = 1'b0;
        value_started     = 1'b0;
        backslash_pending = 1'b0;
    endfunction

    function automatic void put(logic [7:0] b);
        if (run_bytes.size() < MAX_RUN)
            run_bytes.push_back(b);
    endfunction

    function automatic void put_text(string s);
        int i;
        for (i = 0; i < s.len(); i++)
            put(s[i]);
    endfunction

    // entity escaping depends on the kind of line
    function automatic void put_escaped(logic [7:0] b);
        bit in_attr;
        bit in_text;
        in_attr = (line_kind == K_ATTR);
        in_text = (line_kind == K_TEXT || line_kind == K_PI ||
                   line_kind == K_DOCTYPE || line_kind == K_COMMENT);
        if (b == CH_LT && (in_attr || in_text))
            put_text("&lt;");
        else if (b == CH_GT && in_text)
            put_text("&gt;");
        else if (b == CH_AMP && (in_attr || in_text))
            put_text("&amp;");
        else if (b == CH_QUOTE && in_attr)
            put_text("&quot;");
        else
            put(b);
    endfunction

    function automatic void decode_escape(logic [7:0] b);
        if (backslash_pending)
        begin
            backslash_pending = 1'b0;
            if (b == CH_LC_N)
            begin
                put(CH_NL);
                return;
            end
            if (b == CH_LC_T)
            begin
                put(CH_TAB);
                return;
            end
            if (b == CH_BSL)
            begin
                put(CH_BSL);
                return;
            end
            put(CH_BSL);
        end
        if (b == CH_BSL)
            backslash_pending = 1'b1;
        else
            put_escaped(b);
    endfunction

    function automatic void close_line();
        if (backslash_pending)
        begin
            backslash_pending = 1'b0;
            put(CH_BSL);
        end
        case (line_kind)
            K_OPEN:    tag_open = 1'b1;
            K_ATTR:    if (value_started) put(CH_QUOTE);
            K_PI:
            begin
                put_text("?>");
                put(CH_NL);
            end
            K_DOCTYPE:
            begin
                put(CH_GT);
                put(CH_NL);
            end
            K_COMMENT:
            begin
                put_text("-->");
                put(CH_NL);
            end
            K_CDATA:
            begin
                put_text("]]>");
                put(CH_NL);
            end
            K_CLOSE:   put(CH_GT);
            default:   ;
        endcase
        line_kind     = K_IGNORE;
        value_started = 1'b0;
        at_line_start = 1'b1;
    endfunction

    function automatic void open_line(logic [7:0] b);
        bit attr_ok;
        attr_ok = tag_open;
        if (tag_open && b != CH_UC_A)
        begin
            put(CH_GT);
            tag_open = 1'b0;
        end
        at_line_start = 1'b0;
        value_started = 1'b0;
        case (b)
            CH_LPAREN:
            begin
                line_kind = K_OPEN;
                put(CH_LT);
            end
            CH_UC_A:
            begin
                if (attr_ok)
                begin
                    line_kind = K_ATTR;
                    put(CH_SP);
                end
                else
                    line_kind = K_IGNORE;
            end
            CH_DASH:   line_kind = K_TEXT;
            CH_QMARK:
            begin
                line_kind = K_PI;
                put_text("<?");
            end
            CH_UC_D:
            begin
                line_kind = K_DOCTYPE;
                put_text("<!DOCTYPE");
            end
            CH_UC_C:
            begin
                line_kind = K_COMMENT;
                put_text("<!--");
            end
            CH_LBRACK:
            begin
                line_kind = K_CDATA;
                put_text("<![CDATA[");
            end
            CH_RPAREN:
            begin
                line_kind = K_CLOSE;
                put_text("</");
            end
            default:   line_kind = K_IGNORE;
        endcase
    endfunction

    function automatic void line_body(logic [7:0] b);
        case (line_kind)
            K_OPEN, K_CLOSE: put(b);
            K_ATTR:
            begin
                if (value_started)
                    decode_escape(b);
                else if (b == CH_SP)
                begin
                    put_text("=");
                    put(CH_QUOTE);
                    value_started = 1'b1;
                end
                else
                    put(b);
            end
            K_TEXT, K_PI, K_DOCTYPE, K_COMMENT, K_CDATA: decode_escape(b);
            default: ;
        endcase
    endfunction

    // queue up the xml bytes that one pyx byte gives rise to
    function automatic void predict_xml(logic [7:0] b, logic eoi);
        pxc_out_t nxt;
        int       i;
        run_bytes.delete();
        if (at_line_start)
        begin
            if (b == CH_NL)
            begin
                if (tag_open)
                begin
                    put(CH_GT);
                    tag_open = 1'b0;
                end
            end
            else
                open_line(b);
        end
        else if (b == CH_NL)
            close_line();
        else
            line_body(b);
        if (eoi)
        begin
            if (!at_line_start)
                close_line();
            if (tag_open)
                put(CH_GT);
            put(CH_NL);
            clear_line_state();
        end
        for (i = 0; i < run_bytes.size(); i++)
        begin
            nxt.out_byte    = run_bytes[i];
            nxt.last_of_run = (i == run_bytes.size() - 1);
            xml_bytes_due.push_back(nxt);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        pxc_out_t want;
        if (!rst_n)
        begin
            clear_line_state();
            xml_bytes_due.delete();
            mismatches = 0;
            checked_n  = 0;
            pending_n <= 0;
        end
        else
        begin
            if (push && !full)
                predict_xml(item.data_byte, item.end_of_input);
            if (pop && !empty)
            begin
                checked_n++;
                if (xml_bytes_due.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: unexpected output byte %h last %b", $realtime,
                                 result.out_byte, result.last_of_run);
                    mismatches++;
                end
                else
                begin
                    want = xml_bytes_due.pop_front();
                    if (result.out_byte !== want.out_byte ||
                        result.last_of_run !== want.last_of_run)
                    begin
                        if (mismatches < 10)
                            $display("%0t: out_byte exp %h got %h, last_of_run exp %b got %b",
                                     $realtime, want.out_byte, result.out_byte,
                                     want.last_of_run, result.last_of_run);
                        mismatches++;
                    end
                end
            end
            pending_n <= xml_bytes_due.size();
        end
    end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import pxc_pkg::*;

    // rough number of pyx bytes in the random part
    localparam int RANDOM_ITEMS = 420;
    // cycles without any transaction before the run is declared hung
    localparam int QUIET_LIMIT  = 3000;

    logic     clk;
    logic     rst_n;
    logic     push;
    logic     full;
    pxc_in_t  item;
    logic     empty;
    logic     pop;
    pxc_out_t result;

    int fail_count;
    int due_count;
    int checked_count;

    // when set, neither side inserts idle cycles
    bit calm;

    int         quiet_cycles;
    int         items_sent;
    int         streams_sent;
    logic [7:0] stream_q[$];

    pyx_to_xml_stream_converter DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    xml_byte_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .item          (item),
        .empty         (empty),
        .pop           (pop),
        .result        (result),
        .fail_count    (fail_count),
        .due_count     (due_count),
        .checked_count (checked_count)
    );

    // 12 ns clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // idle stretch: mostly a few cycles, now and then a long one
    function automatic int idle_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // one transaction on the input side; called and left at a falling edge
    task automatic send_item(input logic [7:0] b, input logic eoi);
        pxc_in_t nxt;
        int      gap;
        gap = 0;
        if (!calm && $urandom_range(0, 3) == 0)
            gap = idle_len();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        nxt.data_byte    = b;
        nxt.end_of_input = eoi;
        push <= 1'b1;
        item <= nxt;
        do
            @(posedge clk);
        while (full);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s, input bit eoi_last);
        int i;
        for (i = 0; i < s.len(); i++)
            send_item(s[i], eoi_last && (i == s.len() - 1));
    endtask

    // hold the sender back until every predicted byte has come out
    task automatic drain();
        push <= 1'b0;
        while (due_count != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    // body bytes lean on the characters that get escaped or decoded
    function automatic logic [7:0] body_char();
        int         r;
        logic [7:0] b;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 8'(8'h61 + $urandom_range(0, 25));
        if (r < 55)
            return CH_SP;
        if (r < 62)
            return CH_LT;
        if (r < 67)
            return CH_GT;
        if (r < 72)
            return CH_AMP;
        if (r < 77)
            return CH_QUOTE;
        if (r < 87)
            return CH_BSL;
        if (r < 92)
            return ($urandom_range(0, 1) == 0) ? CH_LC_N : CH_LC_T;
        b = 8'($urandom_range(0, 255));
        return (b == CH_NL) ? 8'hFF : b;
    endfunction

    function automatic void add_name();
        repeat ($urandom_range(1, 4))
            stream_q.push_back(8'(8'h61 + $urandom_range(0, 25)));
    endfunction

    function automatic void add_body(int max_len);
        repeat ($urandom_range(0, max_len))
            stream_q.push_back(body_char());
    endfunction

    // one pyx document: a handful of lines, mostly well formed, some noise
    function automatic void build_stream();
        int k;
        stream_q.delete();
        repeat ($urandom_range(1, 8))
        begin
            k = $urandom_range(0, 99);
            if (k < 22)
            begin
                stream_q.push_back(CH_LPAREN);
                add_name();
                stream_q.push_back(CH_NL);
                repeat ($urandom_range(0, 2))
                begin
                    stream_q.push_back(CH_UC_A);
                    add_name();
                    if ($urandom_range(0, 4) != 0)
                    begin
                        stream_q.push_back(CH_SP);
                        add_body(5);
                    end
                    stream_q.push_back(CH_NL);
                end
            end
            else if (k < 64)
            begin
                // text, processing instruction, doctype, comment or cdata
                case ($urandom_range(0, 4))
                    0:       stream_q.push_back(CH_DASH);
                    1:       stream_q.push_back(CH_QMARK);
                    2:       stream_q.push_back(CH_UC_D);
                    3:       stream_q.push_back(CH_UC_C);
                    default: stream_q.push_back(CH_LBRACK);
                endcase
                add_body(6);
                stream_q.push_back(CH_NL);
            end
            else if (k < 78)
            begin
                stream_q.push_back(CH_RPAREN);
                add_name();
                stream_q.push_back(CH_NL);
            end
            else if (k < 84)
                stream_q.push_back(CH_NL);
            else if (k < 88)
            begin
                // attribute line, whether or not a tag is pending
                stream_q.push_back(CH_UC_A);
                add_name();
                stream_q.push_back(CH_SP);
                add_body(3);
                stream_q.push_back(CH_NL);
            end
            else
            begin
                // noise: any first byte, raw bytes after it
                repeat ($urandom_range(1, 5))
                    stream_q.push_back(8'($urandom_range(0, 255)));
                stream_q.push_back(CH_NL);
            end
        end
        // sometimes the stream stops in the middle of a line
        if ($urandom_range(0, 2) == 0 && stream_q.size() > 1)
            void'(stream_q.pop_back());
    endfunction

    task automatic send_stream();
        int i;
        for (i = 0; i < stream_q.size(); i++)
            send_item(stream_q[i], i == stream_q.size() - 1);
        streams_sent++;
    endtask

    // result side: pop mostly high, with stalls of random length
    initial
    begin : result_side
        int stall_left;
        stall_left = 0;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else
            begin
                pop <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0)
                    stall_left = idle_len();
            end
        end
    end

    // watchdog on transactions of either side
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else
        begin
            if ((push && !full) || (pop && !empty))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles, %0d bytes outstanding",
                         QUIET_LIMIT, due_count);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int random_start;
        push         = 1'b0;
        item         = '0;
        calm         = 1'b0;
        items_sent   = 0;
        streams_sent = 0;
        rst_n        = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed stream: tag with an escaped attribute value, a lone backslash,
        // decoded newline, zero and all-ones bytes, backslash at line end,
        // comment, then a close tag cut short by the end of input
        send_text("(a\nAk <\"&\\q\n-\\n>", 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_text("\\\nC&\n)a", 1'b1);
        streams_sent++;
        drain();

        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            // every few documents both sides run flat out
            calm = (streams_sent % 7 == 3);
            build_stream();
            send_stream();
            if (streams_sent == 8)
                drain();
        end
        calm = 1'b0;
        push <= 1'b0;

        while (due_count != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("sent %0d pyx bytes in %0d documents, compared %0d xml bytes",
                 items_sent, streams_sent, checked_count);
        $display("mismatching xml bytes: %0d", fail_count);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: pyx_to_xml_stream_converter.f
rtl/pxc_pkg.sv
rtl/pxc_front.sv
rtl/pxc_queue.sv
rtl/pxc_back.sv
rtl/pyx_to_xml_stream_converter.sv
test/xml_byte_checker.sv
test/testbench.sv
